### hw/rtl/stlc_pkg.sv
// Package for the serial touch link controller.
// Holds the request kinds, event codes, protocol bytes, parser phases and test modes,
// register indexes and reset values. No dependencies.
package stlc_pkg;

	// request kind carried on s_tuser
	localparam logic CMD_BYTE = 1'b0;
	localparam logic CMD_TICK = 1'b1;

	// event codes carried on m_tuser
	localparam logic [2:0] EV_NONE      = 3'd0;
	localparam logic [2:0] EV_HANDSHAKE = 3'd1;
	localparam logic [2:0] EV_PRESS     = 3'd2;
	localparam logic [2:0] EV_LONG      = 3'd3;
	localparam logic [2:0] EV_RELEASE   = 3'd4;
	localparam logic [2:0] EV_FORCED    = 3'd5;
	localparam logic [2:0] EV_TEST      = 3'd6;

	// handshake reply and packet header bytes
	localparam logic [7:0] HS_BYTE0   = 8'h0A;
	localparam logic [7:0] HS_BYTE1   = 8'h01;
	localparam logic [7:0] HS_BYTE2   = 8'h41;
	localparam logic [7:0] HDR_DOWN   = 8'h81;
	localparam logic [7:0] HDR_UP     = 8'h80;
	localparam logic [7:0] X_HIGH_MAX = 8'h10;

	// parser phases
	localparam logic [2:0] PH_0 = 3'd0;
	localparam logic [2:0] PH_1 = 3'd1;
	localparam logic [2:0] PH_2 = 3'd2;
	localparam logic [2:0] PH_3 = 3'd3;
	localparam logic [2:0] PH_4 = 3'd4;

	// test modes
	localparam logic [1:0] TM_NORMAL = 2'd0;
	localparam logic [1:0] TM_BOARD  = 2'd1;

	// register indexes
	localparam logic [2:0] REG_COORD_MIN   = 3'd0;
	localparam logic [2:0] REG_COORD_MAX   = 3'd1;
	localparam logic [2:0] REG_HS_TIMEOUT  = 3'd2;
	localparam logic [2:0] REG_READY_DELAY = 3'd3;
	localparam logic [2:0] REG_LONG_COUNT  = 3'd4;
	localparam logic [2:0] REG_STUCK       = 3'd5;
	localparam logic [2:0] REG_TEST_MODE   = 3'd6;

	// register reset values
	localparam logic [14:0] RST_COORD_MIN   = 15'd50;
	localparam logic [14:0] RST_COORD_MAX   = 15'd4000;
	localparam logic [15:0] RST_HS_TIMEOUT  = 16'd500;
	localparam logic [15:0] RST_READY_DELAY = 16'd500;
	localparam logic [15:0] RST_LONG_COUNT  = 16'd100;
	localparam logic [15:0] RST_STUCK       = 16'd1000;
	localparam logic [1:0]  RST_TEST_MODE   = 2'd0;

endpackage

### hw/rtl/serial_touch_link_controller_unit.sv
// Serial touch link controller, top level.
// A request passes the input register, then the result register, to result valid.
// Throughput: one request per cycle unless results stall (single-pass state update).
// Input and result registers decouple the two sides, so a stalled result does not block
// the next request from being registered while the input register is empty.
// Reset (arst_n low, async): link down, parser idle, all flags/counters cleared, LED off,
// registers back to defaults. Depends on stlc_pkg.
module serial_touch_link_controller_unit (
	input  logic        clk,
	input  logic        arst_n,
	// request side
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] rx_byte
	input  logic        s_tuser,   // [0] command (0 byte, 1 tick)
	// result side
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,   // [14:0] point_x, [29:15] point_y, [30] led_on, [31] zero
	output logic [2:0]  m_tuser,   // [2:0] event_res
	// configuration write port
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [15:0] cfg_data
);

	// ---------------- configuration registers ----------------
	logic [14:0] coord_min_q, coord_max_q;
	logic [15:0] hs_timeout_q, ready_delay_q, long_count_q, stuck_q;
	logic [1:0]  test_mode_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coord_min_q   <= stlc_pkg::RST_COORD_MIN;
			coord_max_q   <= stlc_pkg::RST_COORD_MAX;
			hs_timeout_q  <= stlc_pkg::RST_HS_TIMEOUT;
			ready_delay_q <= stlc_pkg::RST_READY_DELAY;
			long_count_q  <= stlc_pkg::RST_LONG_COUNT;
			stuck_q       <= stlc_pkg::RST_STUCK;
			test_mode_q   <= stlc_pkg::RST_TEST_MODE;
		end else if (cfg_we) begin
			unique case (cfg_index)
				stlc_pkg::REG_COORD_MIN:   coord_min_q   <= cfg_data[14:0];
				stlc_pkg::REG_COORD_MAX:   coord_max_q   <= cfg_data[14:0];
				stlc_pkg::REG_HS_TIMEOUT:  hs_timeout_q  <= cfg_data;
				stlc_pkg::REG_READY_DELAY: ready_delay_q <= cfg_data;
				stlc_pkg::REG_LONG_COUNT:  long_count_q  <= cfg_data;
				stlc_pkg::REG_STUCK:       stuck_q       <= cfg_data;
				stlc_pkg::REG_TEST_MODE:   test_mode_q   <= cfg_data[1:0];
				default: ;  // index 7 is unmapped
			endcase
		end
	end

	// ---------------- stage 1: input register ----------------
	logic       valid_s1;
	logic       cmd_s1;
	logic [7:0] byte_s1;
	logic       out_free;   // result register can take a new result this cycle
	logic       fire;       // stage 1 request is processed this cycle

	assign out_free = !m_tvalid || m_tready;
	assign fire     = valid_s1 && out_free;
	assign s_tready = !valid_s1 || out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			cmd_s1  <= s_tuser;
			byte_s1 <= s_tdata;
		end
	end

	// ---------------- link and touch state ----------------
	logic        link_up_q, req_sent_q, link_ready_q;
	logic [2:0]  phase_q;
	logic [15:0] wait_q;
	logic        down_seen_q, up_seen_q, pending_q;
	logic [11:0] x_build_q;
	logic [14:0] y_build_q, x_held_q, y_held_q;
	logic        pressed_q, long_done_q, led_q;
	logic [15:0] hold_q;

	logic        link_up_d, req_sent_d, link_ready_d;
	logic [2:0]  phase_d;
	logic [15:0] wait_d;
	logic        down_seen_d, up_seen_d, pending_d;
	logic [11:0] x_build_d;
	logic [14:0] y_build_d, x_held_d, y_held_d;
	logic        pressed_d, long_done_d, led_d;
	logic [15:0] hold_d;

	logic [2:0]  ev;
	logic        with_pt;
	logic        in_win;
	logic [15:0] wait_inc, hold_inc;

	// window check runs on the held point, which ticks never change
	assign in_win = (x_held_q > coord_min_q) && (x_held_q < coord_max_q) &&
	                (y_held_q > coord_min_q) && (y_held_q < coord_max_q);
	assign wait_inc = wait_q + 16'd1;
	assign hold_inc = hold_q + 16'd1;

	always_comb begin
		link_up_d    = link_up_q;
		req_sent_d   = req_sent_q;
		link_ready_d = link_ready_q;
		phase_d      = phase_q;
		wait_d       = wait_q;
		down_seen_d  = down_seen_q;
		up_seen_d    = up_seen_q;
		pending_d    = pending_q;
		x_build_d    = x_build_q;
		y_build_d    = y_build_q;
		x_held_d     = x_held_q;
		y_held_d     = y_held_q;
		pressed_d    = pressed_q;
		long_done_d  = long_done_q;
		led_d        = led_q;
		hold_d       = hold_q;
		ev           = stlc_pkg::EV_NONE;
		with_pt      = 1'b0;

		if (cmd_s1 == stlc_pkg::CMD_BYTE) begin
			if (!link_up_q) begin
				// handshake reply parser; bytes before a request are dropped
				if (req_sent_q) begin
					unique case (phase_q)
						stlc_pkg::PH_0: begin
							if (byte_s1 == stlc_pkg::HS_BYTE0) phase_d = stlc_pkg::PH_1;
						end
						stlc_pkg::PH_1: begin
							phase_d = (byte_s1 == stlc_pkg::HS_BYTE1) ? stlc_pkg::PH_2
							                                         : stlc_pkg::PH_0;
						end
						stlc_pkg::PH_2: begin
							if (byte_s1 == stlc_pkg::HS_BYTE2) begin
								link_up_d    = 1'b1;
								led_d        = 1'b1;
								wait_d       = '0;
								link_ready_d = 1'b0;
							end
							phase_d = stlc_pkg::PH_0;
						end
						default: phase_d = stlc_pkg::PH_0;
					endcase
				end
			end else if (link_ready_q) begin
				// touch packet parser
				unique case (phase_q)
					stlc_pkg::PH_0: begin
						if (byte_s1 == stlc_pkg::HDR_DOWN) begin
							down_seen_d = 1'b1;
							phase_d     = stlc_pkg::PH_1;
						end else if (byte_s1 == stlc_pkg::HDR_UP) begin
							up_seen_d   = 1'b1;
							down_seen_d = 1'b0;
							phase_d     = stlc_pkg::PH_1;
						end
					end
					stlc_pkg::PH_1: begin
						if (byte_s1 > stlc_pkg::X_HIGH_MAX) begin
							phase_d = stlc_pkg::PH_0;
						end else begin
							x_build_d = {byte_s1[4:0], 7'd0};
							phase_d   = stlc_pkg::PH_2;
						end
					end
					stlc_pkg::PH_2: begin
						x_build_d = x_build_q + {5'd0, byte_s1[6:0]};
						phase_d   = stlc_pkg::PH_3;
					end
					stlc_pkg::PH_3: begin
						y_build_d = {byte_s1, 7'd0};
						phase_d   = stlc_pkg::PH_4;
					end
					stlc_pkg::PH_4: begin
						y_build_d = y_build_q + {8'd0, byte_s1[6:0]};
						if (!pending_q) begin
							pending_d = 1'b1;
							x_held_d  = {3'd0, x_build_q};
							y_held_d  = y_build_q + {8'd0, byte_s1[6:0]};
						end
						phase_d = stlc_pkg::PH_0;
					end
					default: phase_d = stlc_pkg::PH_0;
				endcase
			end
			// bytes during the settle delay are dropped
		end else begin
			if (!link_up_q) begin
				// request the handshake, then count toward a resend
				if (!req_sent_q) begin
					req_sent_d = 1'b1;
					phase_d    = stlc_pkg::PH_0;
					wait_d     = '0;
					ev         = stlc_pkg::EV_HANDSHAKE;
				end else begin
					wait_d = wait_inc;
					if (wait_inc >= hs_timeout_q) req_sent_d = 1'b0;
				end
			end else if (!link_ready_q) begin
				// settle delay after link up
				wait_d = wait_inc;
				if (wait_inc >= ready_delay_q) begin
					wait_d       = '0;
					link_ready_d = 1'b1;
					led_d        = 1'b0;
				end
			end else if (!pressed_q) begin
				if (pending_q) begin
					if (down_seen_q) begin
						if (in_win) begin
							led_d       = 1'b1;
							pressed_d   = 1'b1;
							hold_d      = '0;
							long_done_d = 1'b0;
							ev          = stlc_pkg::EV_PRESS;
							with_pt     = 1'b1;
						end
						down_seen_d = 1'b0;
					end
					pending_d = 1'b0;
				end
			end else if (up_seen_q) begin
				led_d       = 1'b0;
				up_seen_d   = 1'b0;
				down_seen_d = 1'b0;
				pressed_d   = 1'b0;
				pending_d   = 1'b0;
				ev          = stlc_pkg::EV_RELEASE;
			end else if (test_mode_q == stlc_pkg::TM_NORMAL) begin
				if (pending_q) begin
					if (down_seen_q) begin
						if (!long_done_q && in_win) begin
							hold_d = hold_inc;
							if (hold_inc >= long_count_q) begin
								long_done_d = 1'b1;
								ev          = stlc_pkg::EV_LONG;
								with_pt     = 1'b1;
							end
						end
						down_seen_d = 1'b0;
					end
					pending_d = 1'b0;
				end
			end else if (test_mode_q == stlc_pkg::TM_BOARD) begin
				if (pending_q) begin
					if (down_seen_q) begin
						if (in_win) begin
							ev      = stlc_pkg::EV_TEST;
							with_pt = 1'b1;
						end
						down_seen_d = 1'b0;
					end
					pending_d = 1'b0;
				end
			end else begin
				// service mode: force a release after a stuck hold; LED untouched
				hold_d = hold_inc;
				if (hold_inc >= stuck_q) begin
					pressed_d   = 1'b0;
					pending_d   = 1'b0;
					down_seen_d = 1'b0;
					ev          = stlc_pkg::EV_FORCED;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			link_up_q    <= 1'b0;
			req_sent_q   <= 1'b0;
			link_ready_q <= 1'b0;
			phase_q      <= stlc_pkg::PH_0;
			wait_q       <= '0;
			down_seen_q  <= 1'b0;
			up_seen_q    <= 1'b0;
			pending_q    <= 1'b0;
			x_build_q    <= '0;
			y_build_q    <= '0;
			x_held_q     <= '0;
			y_held_q     <= '0;
			pressed_q    <= 1'b0;
			long_done_q  <= 1'b0;
			led_q        <= 1'b0;
			hold_q       <= '0;
		end else if (fire) begin
			link_up_q    <= link_up_d;
			req_sent_q   <= req_sent_d;
			link_ready_q <= link_ready_d;
			phase_q      <= phase_d;
			wait_q       <= wait_d;
			down_seen_q  <= down_seen_d;
			up_seen_q    <= up_seen_d;
			pending_q    <= pending_d;
			x_build_q    <= x_build_d;
			y_build_q    <= y_build_d;
			x_held_q     <= x_held_d;
			y_held_q     <= y_held_d;
			pressed_q    <= pressed_d;
			long_done_q  <= long_done_d;
			led_q        <= led_d;
			hold_q       <= hold_d;
		end
	end

	// ---------------- stage 2: result register ----------------
	logic        out_valid_q;
	logic [2:0]  out_ev_q;
	logic [14:0] out_x_q, out_y_q;
	logic        out_led_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= valid_s1;
		end
	end

	// point fields are zero unless the event carries the held point
	always_ff @(posedge clk) begin
		if (fire) begin
			out_ev_q  <= ev;
			out_x_q   <= with_pt ? x_held_q : 15'd0;
			out_y_q   <= with_pt ? y_held_q : 15'd0;
			out_led_q <= led_d;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tuser  = out_ev_q;
	assign m_tdata  = {1'b0, out_led_q, out_y_q, out_x_q};

endmodule
